@@ src/uce_pkg.sv @@
// ----------------------------------------------------------------------------
// uce_pkg
// Shared types and constants of the endpoint-zero control engine.
// ----------------------------------------------------------------------------
package uce_pkg;

  localparam int BUF_BYTES = 64;
  localparam int IFACES_DEF = 8;
  localparam int CFG_IDX_W = 2;

  localparam logic [2:0] CMD_SETUP = 3'd0;
  localparam logic [2:0] CMD_IN = 3'd1;
  localparam logic [2:0] CMD_OUT = 3'd2;
  localparam logic [2:0] CMD_BUS_RESET = 3'd3;

  localparam logic [1:0] RES_OK = 2'd0;
  localparam logic [1:0] RES_STALL = 2'd1;
  localparam logic [1:0] RES_NODEV = 2'd2;
  localparam logic [1:0] RES_BABBLE = 2'd3;

  localparam logic [1:0] DEV_DEFAULT = 2'd0;
  localparam logic [1:0] DEV_ADDRESSED = 2'd1;
  localparam logic [1:0] DEV_CONFIGURED = 2'd2;

  localparam logic [1:0] PH_SETUP = 2'd0;
  localparam logic [1:0] PH_DATA = 2'd1;
  localparam logic [1:0] PH_STATUS = 2'd2;

  localparam logic [15:0] REQ_SET_ADDRESS = 16'h0005;
  localparam logic [15:0] REQ_GET_STATUS = 16'h8000;
  localparam logic [15:0] REQ_GET_CONFIG = 16'h8008;
  localparam logic [15:0] REQ_SET_CONFIG = 16'h0009;
  localparam logic [15:0] REQ_GET_IFACE = 16'h810A;
  localparam logic [15:0] REQ_SET_IFACE = 16'h010B;
  localparam logic [15:0] REQ_SET_ISOCH_DELAY = 16'h0031;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_VALUE = 2'd0,
    CFG_ATTRIBUTES = 2'd1,
    CFG_IFACE_COUNT = 2'd2,
    CFG_MAX_ALT = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic [7:0] value;
    logic [7:0] attributes;
    logic [3:0] iface_count;
    logic [7:0] max_alt;
  } cfg_t;

  typedef struct packed {
    logic [2:0]  command;
    logic [6:0]  dev_addr;
    logic [3:0]  ep_number;
    logic [3:0]  byte_count;
    logic [63:0] payload;
  } token_t;

  typedef struct packed {
    logic [1:0]  result_code;
    logic [63:0] read_data;
    logic [3:0]  read_length;
  } result_t;

  typedef struct packed {
    logic [1:0]  dev_state;
    logic [6:0]  dev_address;
    logic        halted;
    logic [1:0]  phase;
    logic [15:0] req_word;
    logic [15:0] value_word;
    logic [15:0] index_word;
    logic [15:0] req_len;
    logic [15:0] stage_pos;
    logic        cfg_sel;
    logic [7:0]  buf0;
    logic [7:0]  buf1;
  } state_t;

  typedef struct packed {
    logic       we;
    logic       clr;
    logic [7:0] data;
  } alt_ctl_t;

endpackage

@@ src/uce_token_if.sv @@
// ----------------------------------------------------------------------------
// uce_token_if
// Token channel: valid/ready handshake with one token per transaction.
// ----------------------------------------------------------------------------
interface uce_token_if;
  logic        valid;
  logic        ready;
  logic [2:0]  command;
  logic [6:0]  dev_addr;
  logic [3:0]  ep_number;
  logic [3:0]  byte_count;
  logic [63:0] payload;

  modport source (output valid, command, dev_addr, ep_number, byte_count, payload,
                  input ready);
  modport sink (input valid, command, dev_addr, ep_number, byte_count, payload,
                output ready);
endinterface

@@ src/uce_result_if.sv @@
// ----------------------------------------------------------------------------
// uce_result_if
// Result channel: valid/ready handshake with one result per transaction.
// ----------------------------------------------------------------------------
interface uce_result_if;
  logic        valid;
  logic        ready;
  logic [1:0]  result_code;
  logic [63:0] read_data;
  logic [3:0]  read_length;

  modport source (output valid, result_code, read_data, read_length, input ready);
  modport sink (input valid, result_code, read_data, read_length, output ready);
endinterface

@@ src/usb_control_endpoint_zero_unit.sv @@
// ----------------------------------------------------------------------------
// usb_control_endpoint_zero_unit
// Endpoint-zero control transfer engine with standard request handling.
// A token is taken into the token register, decoded in a single pass, and its
// result taken into the result register when the result side can advance.
// Throughput: one token per cycle while results are taken. Synchronous reset
// clears the valid flags and returns the device and settings to their defaults.
// ----------------------------------------------------------------------------
module usb_control_endpoint_zero_unit #(
  parameter int IFACES = uce_pkg::IFACES_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_wr_en,
  input  logic [uce_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]                 cfg_data,
  uce_token_if.sink                  token,
  uce_result_if.source               result
);
  import uce_pkg::*;

  localparam int IW = (IFACES > 1) ? $clog2(IFACES) : 1;

  cfg_t     cfg;
  state_t   st;
  state_t   st_next;
  token_t   tok;
  logic     tok_vld;
  result_t  res;
  result_t  res_next;
  logic     res_vld;
  logic     advance;
  logic     fire;
  alt_ctl_t alt_ctl;
  logic [IW-1:0] alt_idx;
  logic [7:0] alt [IFACES];

  assign advance = !res_vld || result.ready;
  assign fire = tok_vld && advance;
  assign token.ready = !tok_vld || advance;

  assign result.valid = res_vld;
  assign result.result_code = res.result_code;
  assign result.read_data = res.read_data;
  assign result.read_length = res.read_length;

  uce_engine #(.IFACES(IFACES), .IW(IW)) u_engine (
    .st      (st),
    .cfg     (cfg),
    .tok     (tok),
    .alt     (alt),
    .nxt     (st_next),
    .res     (res_next),
    .alt_ctl (alt_ctl),
    .alt_idx (alt_idx)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.value <= 8'd1;
      cfg.attributes <= 8'd128;
      cfg.iface_count <= 4'd1;
      cfg.max_alt <= 8'd0;
    end else if (cfg_wr_en) begin
      case (cfg_reg_t'(cfg_index))
        CFG_VALUE:       cfg.value <= cfg_data;
        CFG_ATTRIBUTES:  cfg.attributes <= cfg_data;
        CFG_IFACE_COUNT: cfg.iface_count <= cfg_data[3:0];
        CFG_MAX_ALT:     cfg.max_alt <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (token.valid && token.ready) begin
      tok.command <= token.command;
      tok.dev_addr <= token.dev_addr;
      tok.ep_number <= token.ep_number;
      tok.byte_count <= token.byte_count;
      tok.payload <= token.payload;
    end
    if (fire) begin
      res <= res_next;
    end
    if (rst) begin
      tok_vld <= 1'b0;
      res_vld <= 1'b0;
      st <= '0;
    end else begin
      if (token.ready) tok_vld <= token.valid;
      if (advance) res_vld <= tok_vld;
      if (fire) st <= st_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < IFACES; i++) alt[i] <= '0;
    end else if (fire) begin
      if (alt_ctl.clr) begin
        for (int i = 0; i < IFACES; i++) alt[i] <= '0;
      end else if (alt_ctl.we) begin
        alt[alt_idx] <= alt_ctl.data;
      end
    end
  end

`ifndef SYNTHESIS
  a_state_hold: assert property (@(posedge clk) disable iff (rst)
    !fire |=> $stable(st)) else $error("state changed without a token");
  a_len_max: assert property (@(posedge clk) disable iff (rst)
    res_vld |-> result.read_length <= 4'd8) else $error("read length above eight");
  a_data_ok: assert property (@(posedge clk) disable iff (rst)
    res_vld && result.read_length != 4'd0 |-> result.result_code == RES_OK)
    else $error("data returned on a failed token");
  a_phase: assert property (@(posedge clk) disable iff (rst)
    st.phase == PH_SETUP || st.phase == PH_DATA || st.phase == PH_STATUS)
    else $error("illegal control phase");
`endif

endmodule

@@ src/uce_engine.sv @@
// ----------------------------------------------------------------------------
// uce_engine
// Token decode, phase tracking and standard request execution for one token.
// ----------------------------------------------------------------------------
module uce_engine #(
  parameter int IFACES = uce_pkg::IFACES_DEF,
  parameter int IW = (IFACES > 1) ? $clog2(IFACES) : 1
) (
  input  uce_pkg::state_t   st,
  input  uce_pkg::cfg_t     cfg,
  input  uce_pkg::token_t   tok,
  input  logic [7:0]        alt [IFACES],
  output uce_pkg::state_t   nxt,
  output uce_pkg::result_t  res,
  output uce_pkg::alt_ctl_t alt_ctl,
  output logic [IW-1:0]     alt_idx
);
  import uce_pkg::*;

  logic        addressed;
  logic        checked;
  logic        run_rq;
  logic        setup_go;
  logic        is_in;
  logic        ix_ok;
  logic [3:0]  n0;
  logic [3:0]  n;
  logic [15:0] left;

  assign addressed = (st.dev_state == DEV_ADDRESSED) || (st.dev_state == DEV_CONFIGURED);
  assign is_in = (tok.command == CMD_IN);

  always_comb begin
    nxt = st;
    res = '0;
    res.result_code = RES_OK;
    alt_ctl = '0;
    checked = 1'b0;
    run_rq = 1'b0;
    setup_go = 1'b0;
    n0 = (tok.byte_count > 4'd8) ? 4'd8 : tok.byte_count;
    left = (st.stage_pos <= st.req_len) ? st.req_len - st.stage_pos : 16'd0;
    n = ({12'd0, n0} > left) ? left[3:0] : n0;

    if (tok.command == CMD_BUS_RESET) begin
      nxt.req_word = '0;
      nxt.phase = PH_SETUP;
      nxt.dev_state = DEV_DEFAULT;
    end else if (addressed && (tok.dev_addr != st.dev_address)) begin
      res.result_code = RES_NODEV;
    end else begin
      checked = 1'b1;
      if (tok.ep_number != 4'd0) begin
        if ((tok.command == CMD_IN || tok.command == CMD_OUT) && tok.byte_count == 4'd0) begin
          res.result_code = RES_OK;
        end else begin
          res.result_code = RES_STALL;
        end
      end else if (st.halted && tok.command != CMD_SETUP) begin
        res.result_code = RES_STALL;
      end else if (tok.command == CMD_SETUP) begin
        if (tok.byte_count != 4'd8) begin
          res.result_code = RES_STALL;
        end else begin
          nxt.halted = 1'b0;
          nxt.req_word = {tok.payload[7:0], tok.payload[15:8]};
          nxt.value_word = tok.payload[31:16];
          nxt.index_word = tok.payload[47:32];
          nxt.req_len = tok.payload[63:48];
          nxt.stage_pos = '0;
          if (tok.payload[63:48] > 16'(BUF_BYTES)) begin
            res.result_code = RES_BABBLE;
          end else begin
            nxt.buf0 = '0;
            nxt.buf1 = '0;
            setup_go = 1'b1;
            run_rq = tok.payload[7];
          end
        end
      end else if (tok.command == CMD_IN || tok.command == CMD_OUT) begin
        if (st.phase == PH_DATA) begin
          if (is_in != st.req_word[15]) begin
            res.result_code = RES_STALL;
          end else begin
            if (is_in) begin
              if (st.stage_pos == 16'd0) begin
                if (n >= 4'd1) res.read_data[7:0] = st.buf0;
                if (n >= 4'd2) res.read_data[15:8] = st.buf1;
              end else if (st.stage_pos == 16'd1 && n >= 4'd1) begin
                res.read_data[7:0] = st.buf1;
              end
              res.read_length = n;
            end
            nxt.stage_pos = st.stage_pos + {12'd0, n};
            if (nxt.stage_pos >= st.req_len) nxt.phase = PH_STATUS;
          end
        end else if (st.phase == PH_STATUS) begin
          run_rq = is_in && !st.req_word[15];
          nxt.phase = PH_SETUP;
        end
      end else begin
        res.result_code = RES_NODEV;
      end
    end

    ix_ok = (nxt.index_word < {12'd0, cfg.iface_count}) &&
            (nxt.index_word < 16'(IFACES));
    alt_idx = nxt.index_word[IW-1:0];

    if (run_rq) begin
      case (nxt.req_word)
        REQ_SET_ADDRESS: begin
          nxt.dev_address = nxt.value_word[6:0];
          nxt.dev_state = DEV_ADDRESSED;
        end
        REQ_GET_STATUS: begin
          if (nxt.value_word != 16'd0) begin
            res.result_code = RES_STALL;
          end else begin
            nxt.buf0 = {6'd0, nxt.cfg_sel & cfg.attributes[5], nxt.cfg_sel & cfg.attributes[6]};
            nxt.buf1 = '0;
          end
        end
        REQ_GET_CONFIG: begin
          nxt.buf0 = nxt.cfg_sel ? cfg.value : 8'd0;
        end
        REQ_SET_CONFIG: begin
          if (!addressed) begin
            res.result_code = RES_STALL;
          end else if (nxt.value_word[7:0] == 8'd0) begin
            nxt.cfg_sel = 1'b0;
            nxt.dev_state = DEV_ADDRESSED;
            alt_ctl.clr = 1'b1;
          end else if (nxt.value_word[7:0] == cfg.value) begin
            nxt.cfg_sel = 1'b1;
            nxt.dev_state = DEV_CONFIGURED;
            alt_ctl.clr = 1'b1;
          end else begin
            res.result_code = RES_STALL;
          end
        end
        REQ_GET_IFACE: begin
          if (st.dev_state != DEV_CONFIGURED || !st.cfg_sel || !ix_ok) begin
            res.result_code = RES_STALL;
          end else begin
            nxt.buf0 = alt[alt_idx];
          end
        end
        REQ_SET_IFACE: begin
          if (st.dev_state != DEV_CONFIGURED || !st.cfg_sel || !ix_ok ||
              nxt.value_word > {8'd0, cfg.max_alt}) begin
            res.result_code = RES_STALL;
          end else begin
            alt_ctl.we = 1'b1;
            alt_ctl.data = nxt.value_word[7:0];
          end
        end
        REQ_SET_ISOCH_DELAY: begin
          res.result_code = RES_OK;
        end
        default: begin
          res.result_code = RES_STALL;
        end
      endcase
    end

    if (setup_go && res.result_code == RES_OK) begin
      nxt.phase = (nxt.req_len != 16'd0) ? PH_DATA : PH_STATUS;
    end

    if (checked && res.result_code != RES_OK) begin
      nxt.phase = PH_SETUP;
      nxt.halted = 1'b1;
      res.read_data = '0;
      res.read_length = '0;
      alt_ctl = '0;
    end
  end

endmodule
